@@ hdl/srd_pkg.sv @@
// Shared constants, tables and helpers for the record deframer.
package srd_pkg;

    localparam int unsigned HEADER_WORDS    = 4;
    localparam int unsigned HEAD_SHIFT      = 3;

    localparam logic [15:0] SYNC_DS         = 16'd17491;
    localparam logic [15:0] KEY_SHORT       = 16'd21040;
    localparam logic [15:0] KEY_LONG        = 16'd21041;
    localparam logic [15:0] OUT_MARK        = 16'd17492;
    localparam logic [15:0] RANGE_LO        = 16'd32;
    localparam logic [15:0] RANGE_HI        = 16'd4080;
    localparam logic [6:0]  NUM_HEADS_RESET = 7'd16;

    // One-based source positions of the reordered data words
    localparam logic [6:0] PERM36 [36] = '{
        7'd29, 7'd35, 7'd17, 7'd19, 7'd1,  7'd7,  7'd33, 7'd25, 7'd21,
        7'd15, 7'd11, 7'd5,  7'd31, 7'd27, 7'd23, 7'd13, 7'd9,  7'd3,
        7'd32, 7'd28, 7'd24, 7'd14, 7'd10, 7'd6,  7'd34, 7'd26, 7'd22,
        7'd16, 7'd12, 7'd4,  7'd30, 7'd36, 7'd18, 7'd20, 7'd2,  7'd8};

    localparam logic [6:0] PERM72 [72] = '{
        7'd63, 7'd71, 7'd59, 7'd60, 7'd72, 7'd64, 7'd67, 7'd55, 7'd51,
        7'd52, 7'd56, 7'd68, 7'd39, 7'd47, 7'd43, 7'd44, 7'd48, 7'd40,
        7'd35, 7'd27, 7'd31, 7'd32, 7'd28, 7'd36, 7'd7,  7'd19, 7'd23,
        7'd24, 7'd20, 7'd8,  7'd11, 7'd15, 7'd3,  7'd16, 7'd4,  7'd12,
        7'd61, 7'd69, 7'd57, 7'd58, 7'd70, 7'd62, 7'd65, 7'd53, 7'd49,
        7'd50, 7'd54, 7'd66, 7'd37, 7'd45, 7'd41, 7'd42, 7'd46, 7'd38,
        7'd33, 7'd25, 7'd29, 7'd30, 7'd26, 7'd34, 7'd5,  7'd17, 7'd21,
        7'd22, 7'd18, 7'd6,  7'd9,  7'd13, 7'd1,  7'd14, 7'd2,  7'd10};

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } t_state;

    function automatic logic [15:0] swap16(input logic [15:0] w);
        return {w[7:0], w[15:8]};
    endfunction

    // Zero-based data index placed at output data position i
    function automatic logic [6:0] perm_src(input logic [6:0] i, input logic long_rec);
        logic [6:0] s;
        if (long_rec && i < 7'd72) begin
            s = PERM72[i] - 7'd1;
        end else if (i < 7'd36) begin
            s = PERM36[i[5:0]] - 7'd1;
        end else begin
            s = i;
        end
        return s;
    endfunction

endpackage

@@ hdl/srd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module srd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/sync_record_deframe_reorder.sv @@
// Top level: sync hunt, record capture into RAM, reordered record emission.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  input    | i_word_valid / o_word_ready | i_word
//  output   | o_out_valid / i_out_ready   | o_out_word, o_head_index,
//           |                             | o_last_word, o_accepted_count
//  config   | i_cfg_wr_en                 | i_cfg_wr_data (num_heads)
//
// Words are taken one per cycle while hunting and while a record is captured.
// An accepted record is then read back from the data RAM in permuted order,
// one word per cycle while the output is not stalled, HEADER_WORDS+DATA_WORDS
// words through the registered RAM read; input is held off during that readback.
// Output stalls freeze the readback pipeline and the RAM read register.
// Reset is synchronous, active low; the RAM contents are not cleared.
module sync_record_deframe_reorder
    import srd_pkg::*;
#(
    parameter int DATA_WORDS = 36,
    parameter int MAX_HEADS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_word_valid,
    output logic        o_word_ready,
    input  logic [15:0] i_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_word,
    output logic [5:0]  o_head_index,
    output logic        o_last_word,
    output logic [31:0] o_accepted_count
);

    localparam int TOTAL = HEADER_WORDS + DATA_WORDS;
    localparam int PW    = $clog2(TOTAL + 1);
    localparam int AW    = $clog2(DATA_WORDS);
    localparam logic [15:0] KEY = (DATA_WORDS == 72) ? KEY_LONG : KEY_SHORT;
    localparam logic [PW-1:0] LAST_POS = PW'(TOTAL - 1);
    localparam logic [PW-1:0] TOTAL_P  = PW'(TOTAL);
    localparam logic [PW-1:0] HDR_P    = PW'(HEADER_WORDS);
    localparam logic [6:0]    LIM_MAX  = 7'(MAX_HEADS);

    t_state         r_state, n_state;
    logic [6:0]     r_num_heads;
    logic [PW-1:0]  r_phase, n_phase;
    logic           r_hunting, n_hunting;
    logic           r_sync_ok, n_sync_ok;
    logic [15:0]    r_head_word, n_head_word;
    logic           r_range_err, n_range_err;
    logic [31:0]    r_count, n_count;
    logic [5:0]     r_head, n_head;

    logic [PW-1:0]  r_k, n_k;
    logic           r_s1_valid, n_s1_valid;
    logic [PW-1:0]  r_s1_k, n_s1_k;
    logic           r_out_valid, n_out_valid;
    logic [15:0]    r_out_word;
    logic [5:0]     r_out_head;
    logic           r_out_last;
    logic [31:0]    r_out_count;

    logic           in_fire;
    logic           advance;
    logic [15:0]    sw;
    logic           word_bad;
    logic           err_now;
    logic [12:0]    quot;
    logic [12:0]    head_full;
    logic [6:0]     lim;
    logic           rec_ok;

    logic           ram_we;
    logic [PW-1:0]  wr_off;
    logic           ram_re;
    logic [PW-1:0]  rd_off;
    logic [6:0]     src_full;
    logic [AW-1:0]  rd_addr;
    logic [15:0]    ram_dout;
    logic [15:0]    s1_word;

    assign o_word_ready = (r_state == ST_COLLECT);
    assign in_fire      = i_word_valid && o_word_ready;
    assign advance      = !r_out_valid || i_out_ready;

    assign sw        = swap16(i_word);
    assign word_bad  = (sw < RANGE_LO) || (sw > RANGE_HI);
    assign err_now   = r_range_err || word_bad;
    assign quot      = r_head_word[15:HEAD_SHIFT];
    assign head_full = quot - 13'd1;
    assign lim       = (r_num_heads > LIM_MAX) ? LIM_MAX : r_num_heads;
    assign rec_ok    = (quot != 13'd0) && !err_now && (head_full < {6'd0, lim});

    assign wr_off   = r_phase - HDR_P;
    assign ram_we   = in_fire && !r_hunting && (r_phase >= HDR_P);

    assign rd_off   = r_k - HDR_P;
    assign src_full = perm_src(7'(rd_off), DATA_WORDS == 72);
    assign rd_addr  = (src_full < 7'(DATA_WORDS)) ? src_full[AW-1:0] : '0;
    assign ram_re   = (r_state == ST_EMIT) && advance && (r_k < TOTAL_P);

    srd_ram #(
        .WIDTH (16),
        .DEPTH (DATA_WORDS)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (wr_off[AW-1:0]),
        .i_wr_data (i_word),
        .i_rd_en   (ram_re),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_dout)
    );

    always_comb begin
        if (r_s1_k == '0) begin
            s1_word = OUT_MARK;
        end else if (r_s1_k < HDR_P) begin
            s1_word = 16'd0;
        end else begin
            s1_word = swap16(ram_dout);
        end
    end

    // Next-state logic: hunt for the sync group, fill the data RAM, then sequence the readback
    always_comb begin
        n_phase     = r_phase;
        n_hunting   = r_hunting;
        n_sync_ok   = r_sync_ok;
        n_head_word = r_head_word;
        n_range_err = r_range_err;
        n_count     = r_count;
        n_head      = r_head;
        n_state     = r_state;
        n_k         = r_k;
        n_s1_valid  = r_s1_valid;
        n_s1_k      = r_s1_k;
        n_out_valid = r_out_valid;

        if (in_fire) begin
            if (r_hunting) begin
                if (r_phase == PW'(2)) begin
                    n_sync_ok = (sw == SYNC_DS);
                end
                if (r_phase >= PW'(3)) begin
                    n_phase = '0;
                    if (r_sync_ok && sw == KEY) begin
                        n_hunting   = 1'b0;
                        n_range_err = 1'b0;
                    end
                    n_sync_ok = 1'b0;
                end else begin
                    n_phase = r_phase + PW'(1);
                end
            end else begin
                if (r_phase == '0) begin
                    n_head_word = i_word;
                end
                if (r_phase >= HDR_P) begin
                    n_range_err = err_now;
                end
                if (r_phase == LAST_POS) begin
                    // Record complete: decide, and start readback if the record is accepted
                    n_phase   = '0;
                    n_hunting = 1'b1;
                    if (rec_ok) begin
                        n_count    = r_count + 32'd1;
                        n_head     = head_full[5:0];
                        n_state    = ST_EMIT;
                        n_k        = '0;
                        n_s1_valid = 1'b0;
                    end
                end else begin
                    n_phase = r_phase + PW'(1);
                end
            end
        end

        if (advance) begin
            n_out_valid = r_s1_valid;
        end

        if (r_state == ST_EMIT && advance) begin
            if (r_k < TOTAL_P) begin
                n_s1_valid = 1'b1;
                n_s1_k     = r_k;
                n_k        = r_k + PW'(1);
            end else begin
                n_s1_valid = 1'b0;
                n_state    = ST_COLLECT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_num_heads <= NUM_HEADS_RESET;
            r_phase     <= '0;
            r_hunting   <= 1'b1;
            r_sync_ok   <= 1'b0;
            r_head_word <= 16'd0;
            r_range_err <= 1'b0;
            r_count     <= 32'd0;
            r_k         <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_num_heads <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_hunting   <= n_hunting;
            r_sync_ok   <= n_sync_ok;
            r_head_word <= n_head_word;
            r_range_err <= n_range_err;
            r_count     <= n_count;
            r_k         <= n_k;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: record head, readback stage index and the output word, head, last flag and count
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_s1_k <= n_s1_k;
        if (advance && r_s1_valid) begin
            r_out_word  <= s1_word;
            r_out_head  <= r_head;
            r_out_last  <= (r_s1_k == LAST_POS);
            r_out_count <= r_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_word       = r_out_word;
    assign o_head_index     = r_out_head;
    assign o_last_word      = r_out_last;
    assign o_accepted_count = r_out_count;

    a_s1_only_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_EMIT))
        else $error("readback stage holds a word outside readback");

    a_count_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_EMIT) |-> (r_count == $past(r_count) + 32'd1))
        else $error("accepted count did not advance by one on a new record");

    a_phase_clear_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_phase == '0 && r_hunting))
        else $error("capture state not reset while a record is read back");

    a_no_input_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !ram_we)
        else $error("data RAM written during readback");

endmodule
